// ===== rtl/spga_pkg.sv =====
// Shared constants, types and helpers for the spring gradient accumulator.
package spga_pkg;

    localparam int NUM_SPRINGS = 1024;
    localparam int IDX_W       = 10;
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 64;
    localparam int FIFO_DEPTH  = 128;
    localparam int FIFO_AW     = 7;
    localparam int CREDITS     = FIFO_DEPTH + 1;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_STIFF_EN = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_EN   = 8'd1;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    // spring attributes carried beside the math
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [30:0]      ks;
        logic [30:0]      rest;
        logic             enabled;
        logic             elong;
    } spr_t;

    // sideband through the square root
    typedef struct packed {
        spr_t        spr;
        logic        pneg;
        logic [63:0] dotmag;
    } sq_side_t;

    // sideband through the divider; d is also the divisor
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [30:0]      ks;
        logic [30:0]      rest;
        logic [31:0]      d;
        logic             active;
        logic             pneg;
    } dv_side_t;

    // update request into the gradient store
    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic               in_range;
        logic               active;
        logic signed [63:0] inc_s;
        logic signed [63:0] inc_l;
    } upd_req_t;

    // one result beat
    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic signed [63:0] stiff_grad;
        logic signed [63:0] len_grad;
        logic               contributed;
    } result_t;

endpackage

// ===== rtl/spring_parameter_gradient_accumulator_top.sv =====
// Top level of the spring stiffness and rest-length gradient accumulator.
//
// Input channel (s_*): one spring per beat: separation, weight difference,
// stiffness, rest length and flags, all Q16.16. Result channel (m_*): one
// beat per input beat, in order: the spring index, both accumulator entries
// after the update, and whether the spring contributed.
// Config channel (cfg_*): index 0 = stiffness gradient enable, index 1 =
// rest-length gradient enable, bit 0 of cfg_wdata; other indexes ignored.
// cfg_ready is always high; write only while no spring is in flight.
//
// Throughput: one spring per clock while s_ready is high. An input beat
// passes the 32-stage square root and 64-stage divider pipelines, then the
// multiply, saturate and store read-modify-write stages, to m_valid.
// Accumulators live in one 1024 x 128 synchronous RAM; a back-to-back update
// of the same spring is forwarded from the previous write.
//
// Reset: enables return to 1 and a clear pass, during which s_ready stays
// low, zeroes the RAM one entry per clock.
// Stall: results drain into a 128-entry queue; the block keeps 129 credits
// (queue plus output register) and drops s_ready only when all are taken, so
// a stalled receiver never loses a result.
module spring_parameter_gradient_accumulator_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // spring input
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [spga_pkg::IDX_W-1:0]      s_spring_index,
    input  logic signed [31:0]              s_sep_x,
    input  logic signed [31:0]              s_sep_y,
    input  logic signed [31:0]              s_sep_z,
    input  logic signed [31:0]              s_weight_x,
    input  logic signed [31:0]              s_weight_y,
    input  logic signed [31:0]              s_weight_z,
    input  logic [30:0]                     s_stiffness,
    input  logic [30:0]                     s_rest_length,
    input  logic                            s_spring_enabled,
    input  logic                            s_elongation_only,
    // result output
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [spga_pkg::IDX_W-1:0]      m_result_index,
    output logic signed [63:0]              m_stiffness_gradient,
    output logic signed [63:0]              m_length_gradient,
    output logic                            m_contributed,
    // register writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [spga_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spga_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import spga_pkg::*;

    // magnitude of a two's complement word; -2^31 maps to 2^31
    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [63:0] mul32(input logic [31:0] a, input logic [31:0] b);
        return 64'(a) * 64'(b);
    endfunction

    // combine the two partial products, saturating to all ones
    function automatic logic [63:0] comb_sat(input logic [63:0] hi, input logic [63:0] lo);
        logic [64:0] t;
        t = {1'b0, hi[31:0], 32'd0} + {1'b0, lo};
        if (hi[63:32] != 32'd0 || t[64]) return '1;
        return t[63:0];
    endfunction

    function automatic logic signed [63:0] to_signed(input logic neg, input logic [63:0] mag);
        if (!neg) return mag[63] ? S64_MAX : $signed(mag);
        return mag[63] ? S64_MIN : -$signed(mag);
    endfunction

    // ---------------- config and credits ----------------
    logic stiff_en_reg;
    logic len_en_reg;
    logic [7:0] occ_reg;
    logic [7:0] occ_next;
    logic clearing;
    logic in_beat;
    logic out_beat;

    assign cfg_ready = 1'b1;
    assign in_beat   = s_valid && s_ready;
    assign out_beat  = m_valid && m_ready;
    assign s_ready   = !clearing && (occ_reg < 8'(CREDITS));

    always_comb begin
        occ_next = occ_reg;
        if (in_beat && !out_beat) occ_next = occ_reg + 1'b1;
        if (!in_beat && out_beat) occ_next = occ_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stiff_en_reg <= 1'b1;
            len_en_reg   <= 1'b1;
            occ_reg      <= '0;
        end else begin
            if (cfg_valid && cfg_index == CFG_STIFF_EN) stiff_en_reg <= cfg_wdata[0];
            if (cfg_valid && cfg_index == CFG_LEN_EN)   len_en_reg   <= cfg_wdata[0];
            occ_reg <= occ_next;
        end
    end

    // ---------------- front: magnitudes, products, sums ----------------
    logic        f1_v_reg, f2_v_reg, f3_v_reg, f4_v_reg;
    spr_t        f1_spr_reg, f2_spr_reg, f3_spr_reg, f4_spr_reg;
    logic [31:0] sm_reg [3];
    logic [31:0] wm_reg [3];
    logic        xn1_reg [3];
    logic        xn2_reg [3];
    logic [63:0] sq_p_reg [3];
    logic [63:0] dp_p_reg [3];
    logic [63:0] sq3_reg, dpos_reg, dneg_reg;
    logic [63:0] sq4_reg, dotmag_reg;
    logic        pneg_reg;
    logic [31:0] sep_w [3];
    logic [31:0] wt_w [3];

    assign sep_w[0] = s_sep_x;
    assign sep_w[1] = s_sep_y;
    assign sep_w[2] = s_sep_z;
    assign wt_w[0]  = s_weight_x;
    assign wt_w[1]  = s_weight_y;
    assign wt_w[2]  = s_weight_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
            f3_v_reg <= 1'b0;
            f4_v_reg <= 1'b0;
        end else begin
            f1_v_reg <= in_beat;
            f2_v_reg <= f1_v_reg;
            f3_v_reg <= f2_v_reg;
            f4_v_reg <= f3_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        f1_spr_reg.idx     <= s_spring_index;
        f1_spr_reg.ks      <= s_stiffness;
        f1_spr_reg.rest    <= s_rest_length;
        f1_spr_reg.enabled <= s_spring_enabled;
        f1_spr_reg.elong   <= s_elongation_only;
        f2_spr_reg <= f1_spr_reg;
        f3_spr_reg <= f2_spr_reg;
        f4_spr_reg <= f3_spr_reg;
        for (int k = 0; k < 3; k++) begin
            sm_reg[k]   <= mag32(sep_w[k]);
            wm_reg[k]   <= mag32(wt_w[k]);
            xn1_reg[k]  <= sep_w[k][31] ^ wt_w[k][31];
            sq_p_reg[k] <= mul32(sm_reg[k], sm_reg[k]);
            dp_p_reg[k] <= mul32(sm_reg[k], wm_reg[k]);
            xn2_reg[k]  <= xn1_reg[k];
        end
        sq3_reg  <= sq_p_reg[0] + sq_p_reg[1] + sq_p_reg[2];
        dpos_reg <= (xn2_reg[0] ? 64'd0 : dp_p_reg[0]) + (xn2_reg[1] ? 64'd0 : dp_p_reg[1])
                  + (xn2_reg[2] ? 64'd0 : dp_p_reg[2]);
        dneg_reg <= (xn2_reg[0] ? dp_p_reg[0] : 64'd0) + (xn2_reg[1] ? dp_p_reg[1] : 64'd0)
                  + (xn2_reg[2] ? dp_p_reg[2] : 64'd0);
        sq4_reg    <= sq3_reg;
        pneg_reg   <= dneg_reg > dpos_reg;
        dotmag_reg <= (dneg_reg > dpos_reg) ? dneg_reg - dpos_reg : dpos_reg - dneg_reg;
    end

    // ---------------- length ----------------
    sq_side_t    sq_in_side;
    logic        sq_out_v;
    logic [31:0] sq_root;
    sq_side_t    sq_out_side;

    assign sq_in_side.spr    = f4_spr_reg;
    assign sq_in_side.pneg   = pneg_reg;
    assign sq_in_side.dotmag = dotmag_reg;

    spga_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (f4_v_reg),
        .in_rad   (sq4_reg),
        .in_side  (sq_in_side),
        .out_valid(sq_out_v),
        .out_root (sq_root),
        .out_side (sq_out_side)
    );

    // activity test
    logic        p_v_reg;
    dv_side_t    p_side_reg;
    logic [63:0] p_num_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) p_v_reg <= 1'b0;
        else          p_v_reg <= sq_out_v;
    end

    always_ff @(posedge aclk) begin
        p_side_reg.idx    <= sq_out_side.spr.idx;
        p_side_reg.ks     <= sq_out_side.spr.ks;
        p_side_reg.rest   <= sq_out_side.spr.rest;
        p_side_reg.d      <= sq_root;
        p_side_reg.pneg   <= sq_out_side.pneg;
        p_side_reg.active <= sq_out_side.spr.enabled && (sq_root != 32'd0)
                          && (!sq_out_side.spr.elong || sq_root > {1'b0, sq_out_side.spr.rest});
        p_num_reg <= sq_out_side.dotmag;
    end

    // ---------------- projection ----------------
    logic        dv_out_v;
    logic [63:0] dv_quo;
    dv_side_t    dv_out_side;

    spga_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (p_v_reg),
        .in_num   (p_num_reg),
        .in_side  (p_side_reg),
        .out_valid(dv_out_v),
        .out_quo  (dv_quo),
        .out_side (dv_out_side)
    );

    // ---------------- increments ----------------
    logic             m0_v_reg, m1_v_reg, m2_v_reg, m3_v_reg;
    logic [IDX_W-1:0] m0_idx_reg, m1_idx_reg, m2_idx_reg, m3_idx_reg;
    logic             m0_act_reg, m1_act_reg, m2_act_reg, m3_act_reg;
    logic             m0_ns_reg, m1_ns_reg, m2_ns_reg;
    logic             m0_nl_reg, m1_nl_reg, m2_nl_reg;
    logic [31:0]      m0_emag_reg;
    logic [30:0]      m0_ks_reg;
    logic [63:0]      m0_q_reg;
    logic [63:0]      ps_lo_reg, ps_hi_reg, pl_lo_reg, pl_hi_reg;
    logic [63:0]      mag_s_reg, mag_l_reg;
    logic signed [63:0] inc_s_reg, inc_l_reg;
    logic             eneg;

    assign eneg = dv_out_side.d < {1'b0, dv_out_side.rest};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m0_v_reg <= 1'b0;
            m1_v_reg <= 1'b0;
            m2_v_reg <= 1'b0;
            m3_v_reg <= 1'b0;
        end else begin
            m0_v_reg <= dv_out_v;
            m1_v_reg <= m0_v_reg;
            m2_v_reg <= m1_v_reg;
            m3_v_reg <= m2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        m0_idx_reg  <= dv_out_side.idx;
        m0_act_reg  <= dv_out_side.active;
        m0_ns_reg   <= eneg ^ dv_out_side.pneg;
        m0_nl_reg   <= !dv_out_side.pneg;
        m0_emag_reg <= eneg ? ({1'b0, dv_out_side.rest} - dv_out_side.d)
                            : (dv_out_side.d - {1'b0, dv_out_side.rest});
        m0_ks_reg   <= dv_out_side.ks;
        m0_q_reg    <= dv_quo;

        m1_idx_reg <= m0_idx_reg;
        m1_act_reg <= m0_act_reg;
        m1_ns_reg  <= m0_ns_reg;
        m1_nl_reg  <= m0_nl_reg;
        ps_lo_reg  <= mul32(m0_emag_reg, m0_q_reg[31:0]);
        ps_hi_reg  <= mul32(m0_emag_reg, m0_q_reg[63:32]);
        pl_lo_reg  <= mul32({1'b0, m0_ks_reg}, m0_q_reg[31:0]);
        pl_hi_reg  <= mul32({1'b0, m0_ks_reg}, m0_q_reg[63:32]);

        m2_idx_reg <= m1_idx_reg;
        m2_act_reg <= m1_act_reg;
        m2_ns_reg  <= m1_ns_reg;
        m2_nl_reg  <= m1_nl_reg;
        mag_s_reg  <= comb_sat(ps_hi_reg, ps_lo_reg);
        mag_l_reg  <= comb_sat(pl_hi_reg, pl_lo_reg);

        m3_idx_reg <= m2_idx_reg;
        m3_act_reg <= m2_act_reg;
        inc_s_reg  <= to_signed(m2_ns_reg, mag_s_reg);
        inc_l_reg  <= to_signed(m2_nl_reg, mag_l_reg);
    end

    // ---------------- store and output ----------------
    upd_req_t req;
    logic     res_valid;
    result_t  res;
    result_t  out_data;

    assign req.idx      = m3_idx_reg;
    assign req.in_range = 32'(m3_idx_reg) < NUM_SPRINGS;
    assign req.active   = m3_act_reg;
    assign req.inc_s    = inc_s_reg;
    assign req.inc_l    = inc_l_reg;

    spga_grad_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req_valid(m3_v_reg),
        .req      (req),
        .stiff_en (stiff_en_reg),
        .len_en   (len_en_reg),
        .clearing (clearing),
        .res_valid(res_valid),
        .res      (res)
    );

    spga_out_fifo u_out_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (res_valid),
        .wr_data  (res),
        .out_valid(m_valid),
        .out_ready(m_ready),
        .out_data (out_data)
    );

    assign m_result_index       = out_data.idx;
    assign m_stiffness_gradient = out_data.stiff_grad;
    assign m_length_gradient    = out_data.len_grad;
    assign m_contributed        = out_data.contributed;

endmodule

// ===== rtl/spga_isqrt.sv =====
// Pipelined floor square root of a 64-bit radicand, two radicand bits per stage.
module spga_isqrt (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  logic [63:0]        in_rad,
    input  spga_pkg::sq_side_t in_side,
    output logic               out_valid,
    output logic [31:0]        out_root,
    output spga_pkg::sq_side_t out_side
);
    import spga_pkg::*;

    logic       v_reg    [SQRT_STAGES];
    logic [63:0] n_reg   [SQRT_STAGES];
    logic [35:0] rem_reg [SQRT_STAGES];
    logic [31:0] root_reg[SQRT_STAGES];
    sq_side_t   side_reg [SQRT_STAGES];

    logic [63:0] n_next   [SQRT_STAGES];
    logic [35:0] rem_next [SQRT_STAGES];
    logic [31:0] root_next[SQRT_STAGES];

    always_comb begin
        logic [63:0] n_src;
        logic [35:0] rem_src;
        logic [31:0] root_src;
        logic [35:0] rem_sh;
        logic [35:0] trial;
        for (int i = 0; i < SQRT_STAGES; i++) begin
            if (i == 0) begin
                n_src    = in_rad;
                rem_src  = '0;
                root_src = '0;
            end else begin
                n_src    = n_reg[i-1];
                rem_src  = rem_reg[i-1];
                root_src = root_reg[i-1];
            end
            rem_sh       = {rem_src[33:0], n_src[63:62]};
            trial        = {2'b00, root_src, 2'b01};
            n_next[i]    = {n_src[61:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_next[i]  = rem_sh - trial;
                root_next[i] = {root_src[30:0], 1'b1};
            end else begin
                rem_next[i]  = rem_sh;
                root_next[i] = {root_src[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SQRT_STAGES; i++) v_reg[i] <= 1'b0;
        end else begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < SQRT_STAGES; i++) v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        side_reg[0] <= in_side;
        for (int i = 1; i < SQRT_STAGES; i++) side_reg[i] <= side_reg[i-1];
        for (int i = 0; i < SQRT_STAGES; i++) begin
            n_reg[i]    <= n_next[i];
            rem_reg[i]  <= rem_next[i];
            root_reg[i] <= root_next[i];
        end
    end

    assign out_valid = v_reg[SQRT_STAGES-1];
    assign out_root  = root_reg[SQRT_STAGES-1];
    assign out_side  = side_reg[SQRT_STAGES-1];

endmodule

// ===== rtl/spga_div.sv =====
// Pipelined restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per stage.
module spga_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  logic [63:0]        in_num,
    input  spga_pkg::dv_side_t in_side,
    output logic               out_valid,
    output logic [63:0]        out_quo,
    output spga_pkg::dv_side_t out_side
);
    import spga_pkg::*;

    logic        v_reg   [DIV_STAGES];
    logic [63:0] num_reg [DIV_STAGES];
    logic [31:0] rem_reg [DIV_STAGES];
    dv_side_t    side_reg[DIV_STAGES];

    logic [63:0] num_next[DIV_STAGES];
    logic [31:0] rem_next[DIV_STAGES];

    always_comb begin
        logic [63:0] num_src;
        logic [31:0] rem_src;
        logic [31:0] dvs;
        logic [32:0] r;
        for (int i = 0; i < DIV_STAGES; i++) begin
            if (i == 0) begin
                num_src = in_num;
                rem_src = '0;
                dvs     = in_side.d;
            end else begin
                num_src = num_reg[i-1];
                rem_src = rem_reg[i-1];
                dvs     = side_reg[i-1].d;
            end
            r = {rem_src, num_src[63]};
            if (r >= {1'b0, dvs}) begin
                rem_next[i] = 32'(r - {1'b0, dvs});
                num_next[i] = {num_src[62:0], 1'b1};
            end else begin
                rem_next[i] = r[31:0];
                num_next[i] = {num_src[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIV_STAGES; i++) v_reg[i] <= 1'b0;
        end else begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < DIV_STAGES; i++) v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        side_reg[0] <= in_side;
        for (int i = 1; i < DIV_STAGES; i++) side_reg[i] <= side_reg[i-1];
        for (int i = 0; i < DIV_STAGES; i++) begin
            num_reg[i] <= num_next[i];
            rem_reg[i] <= rem_next[i];
        end
    end

    assign out_valid = v_reg[DIV_STAGES-1];
    assign out_quo   = num_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];

endmodule

// ===== rtl/spga_grad_store.sv =====
// Gradient store: read-modify-write of both accumulators with forwarding and reset clear.
module spga_grad_store (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              req_valid,
    input  spga_pkg::upd_req_t req,
    input  logic              stiff_en,
    input  logic              len_en,
    output logic              clearing,
    output logic              res_valid,
    output spga_pkg::result_t res
);
    import spga_pkg::*;

    logic [127:0] mem [NUM_SPRINGS];

    logic             clearing_reg;
    logic [IDX_W-1:0] clr_addr_reg;
    logic             rq_valid_reg;
    upd_req_t         rq_reg;
    logic [127:0]     rd_data_reg;
    logic             fwd_valid_reg;
    logic [IDX_W-1:0] fwd_idx_reg;
    logic [127:0]     fwd_data_reg;

    logic [127:0]       acc;
    logic signed [63:0] new_s;
    logic signed [63:0] new_l;
    logic               upd;
    logic               wr_en;

    function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            return a[63] ? S64_MIN : S64_MAX;
        return s;
    endfunction

    // the entry written last cycle is not yet visible in the read data
    assign acc = (fwd_valid_reg && fwd_idx_reg == rq_reg.idx) ? fwd_data_reg : rd_data_reg;
    assign upd = rq_reg.active && rq_reg.in_range;

    always_comb begin
        new_s = acc[127:64];
        new_l = acc[63:0];
        if (upd && stiff_en) new_s = add_sat(acc[127:64], rq_reg.inc_s);
        if (upd && len_en)   new_l = add_sat(acc[63:0], rq_reg.inc_l);
    end

    assign wr_en = rq_valid_reg && rq_reg.in_range;

    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            mem[rq_reg.idx] <= {new_s, new_l};
        end
        if (req_valid) rd_data_reg <= mem[req.idx];
        rq_reg       <= req;
        fwd_idx_reg  <= rq_reg.idx;
        fwd_data_reg <= {new_s, new_l};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            rq_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            if (clearing_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == IDX_W'(NUM_SPRINGS - 1)) clearing_reg <= 1'b0;
            end
            rq_valid_reg  <= req_valid;
            fwd_valid_reg <= wr_en;
        end
    end

    assign clearing        = clearing_reg;
    assign res_valid       = rq_valid_reg;
    assign res.idx         = rq_reg.idx;
    assign res.stiff_grad  = rq_reg.in_range ? new_s : 64'sd0;
    assign res.len_grad    = rq_reg.in_range ? new_l : 64'sd0;
    assign res.contributed = rq_reg.active;

endmodule

// ===== rtl/spga_out_fifo.sv =====
// Result queue with registered read feeding the output beat register.
module spga_out_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    input  spga_pkg::result_t wr_data,
    output logic              out_valid,
    input  logic              out_ready,
    output spga_pkg::result_t out_data
);
    import spga_pkg::*;

    result_t mem [FIFO_DEPTH];

    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;
    logic [FIFO_AW:0]   count_next;
    logic               out_valid_reg;
    result_t            out_data_reg;
    logic               pop;

    assign pop = (count_reg != '0) && (!out_valid_reg || out_ready);

    always_comb begin
        count_next = count_reg;
        if (wr_valid && !pop) count_next = count_reg + 1'b1;
        if (!wr_valid && pop) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (wr_valid) mem[wr_ptr_reg] <= wr_data;
        if (pop) out_data_reg <= mem[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (wr_valid) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop) rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
            if (pop) out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
